// ===== design/ltc_pkg.sv =====
// Shared types and constants for the text line/column tracker.
// No dependencies; used by ltc_step and text_line_column_tracker.
package ltc_pkg;

  // Counter width for line, column and byte offset
  localparam int CNT_W = 31;
  localparam int OFS_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Byte codes with special meaning
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_START_OFFSET = 1'b0;
  localparam logic CFG_END_OFFSET   = 1'b1;

  // Scan state carried from one request to the next
  typedef struct packed {
    logic [CNT_W-1:0] line;
    logic [CNT_W-1:0] column;
    logic [CNT_W-1:0] pos;
    logic             pending_cr;
    logic             have_start;
    logic             scan_done;
    logic [CNT_W-1:0] held_line;
    logic [CNT_W-1:0] held_column;
    logic [CNT_W-1:0] held_pos;
  } scan_state_t;

  // One result: start point and end point
  typedef struct packed {
    logic [CNT_W-1:0] start_line;
    logic [CNT_W-1:0] start_column;
    logic [CNT_W-1:0] start_pos;
    logic [CNT_W-1:0] end_line;
    logic [CNT_W-1:0] end_column;
    logic [CNT_W-1:0] end_pos;
  } result_t;

  localparam scan_state_t SCAN_INIT = '{
    line:        CNT_W'(1),
    column:      CNT_W'(1),
    pos:         '0,
    pending_cr:  1'b0,
    have_start:  1'b0,
    scan_done:   1'b0,
    held_line:   CNT_W'(1),
    held_column: CNT_W'(1),
    held_pos:    '0
  };

  // Saturating add of a small step
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                input logic [4:0] d);
    logic [CNT_W:0] sum;
    sum = {1'b0, v} + (CNT_W+1)'(d);
    return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

endpackage

// ===== design/text_line_column_tracker.sv =====
// Top level of the text line/column tracker: input stage, scan state,
// result register and configuration registers. Depends on ltc_pkg, ltc_step.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    req_type, src_byte
//  out      source     out_valid / out_ready  start_*/end_* line, column, pos
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle while in_ready is high; a request that yields a result passes
// through the input register, then the scan update loads the result register.
// The scan update holds while a result is waiting and out_ready is low,
// which in turn holds in_ready low once the input register is full.
// Reset restarts the scan and clears both offsets; cfg_ready is always high.
module text_line_column_tracker #(
  parameter int TAB_SIZE = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [7:0]                    src_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ltc_pkg::CNT_W-1:0]     start_line,
  output logic [ltc_pkg::CNT_W-1:0]     start_column,
  output logic [ltc_pkg::CNT_W-1:0]     start_pos,
  output logic [ltc_pkg::CNT_W-1:0]     end_line,
  output logic [ltc_pkg::CNT_W-1:0]     end_column,
  output logic [ltc_pkg::CNT_W-1:0]     end_pos,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [ltc_pkg::OFS_W-1:0]     cfg_data
);
  import ltc_pkg::*;

  localparam int PW = (TAB_SIZE > 1) ? $clog2(TAB_SIZE) : 1;
  localparam logic [PW-1:0] PHASE_INIT = (TAB_SIZE > 1) ? PW'(1) : '0;

  logic              s1_valid;
  logic              s1_req_type;
  logic [7:0]        s1_byte;
  logic              advance;
  scan_state_t       state;
  scan_state_t       state_next;
  logic [PW-1:0]     phase;
  logic [PW-1:0]     phase_next;
  logic              emit;
  result_t           result;
  logic [OFS_W-1:0]  start_offset;
  logic [OFS_W-1:0]  end_offset;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_req_type <= req_type;
      s1_byte     <= src_byte;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
      end_offset   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_OFFSET: start_offset <= cfg_data;
        CFG_END_OFFSET:   end_offset   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Scan update
  ltc_step #(.TAB_SIZE(TAB_SIZE)) u_step (
    .state        (state),
    .phase        (phase),
    .req_type     (s1_req_type),
    .src_byte     (s1_byte),
    .start_offset (start_offset),
    .end_offset   (end_offset),
    .state_next   (state_next),
    .phase_next   (phase_next),
    .emit         (emit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_INIT;
      phase <= PHASE_INIT;
    end else if (advance) begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      start_line   <= result.start_line;
      start_column <= result.start_column;
      start_pos    <= result.start_pos;
      end_line     <= result.end_line;
      end_column   <= result.end_column;
      end_pos      <= result.end_pos;
    end
  end

  // Checks
  a_done_no_cr: assert property (@(posedge clk) disable iff (rst)
    state.scan_done |-> !state.pending_cr)
    else $error("scan stopped with a CR still pending");

  a_start_behind: assert property (@(posedge clk) disable iff (rst)
    state.have_start |-> (state.held_pos <= state.pos))
    else $error("captured start lies past current offset");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_req_type == REQ_END) |=>
      (state.line == CNT_W'(1) && state.pos == '0 && !state.scan_done &&
       !state.have_start))
    else $error("end of source did not restart the scan");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state.line != '0) && (state.column != '0))
    else $error("line or column reached zero");

endmodule

// ===== design/ltc_step.sv =====
// Next-state and result logic for one request of the line/column tracker.
// Depends on ltc_pkg (state and result types, byte codes, saturating add).
module ltc_step #(
  parameter int TAB_SIZE = 4,
  localparam int PW = (TAB_SIZE > 1) ? $clog2(TAB_SIZE) : 1
) (
  input  ltc_pkg::scan_state_t           state,
  input  logic [PW-1:0]                  phase,
  input  logic                           req_type,
  input  logic [7:0]                     src_byte,
  input  logic [ltc_pkg::OFS_W-1:0]      start_offset,
  input  logic [ltc_pkg::OFS_W-1:0]      end_offset,
  output ltc_pkg::scan_state_t           state_next,
  output logic [PW-1:0]                  phase_next,
  output logic                           emit,
  output ltc_pkg::result_t               result
);
  import ltc_pkg::*;

  // Column phase (column mod TAB_SIZE) of column 1
  localparam logic [PW-1:0] PHASE_INIT = (TAB_SIZE > 1) ? PW'(1) : '0;
  localparam logic [PW-1:0] PHASE_LAST = PW'(TAB_SIZE - 1);
  localparam logic [4:0]    TAB_PLUS1  = 5'(TAB_SIZE + 1);

  scan_state_t     res_st;    // after resolving a held CR and capturing start
  logic [PW-1:0]   res_phase;
  logic            is_end;
  logic            is_lf;
  logic            at_end_ofs;
  logic [4:0]      tab_step;

  always_comb begin
    is_end = (req_type == REQ_END);
    is_lf  = !is_end && (src_byte == CH_LF);

    // A held CR ends a line unless this byte is its LF
    res_st    = state;
    res_phase = phase;
    if (state.pending_cr) begin
      if (!is_lf) begin
        res_st.line   = sat_add(state.line, 5'd1);
        res_st.column = CNT_W'(1);
        res_phase     = PHASE_INIT;
      end
      res_st.pending_cr = 1'b0;
    end

    // Capture start point
    if (!state.have_start && ({1'b0, res_st.pos} == start_offset)) begin
      res_st.held_line   = res_st.line;
      res_st.held_column = res_st.column;
      res_st.held_pos    = res_st.pos;
      res_st.have_start  = 1'b1;
    end

    // Result fields
    if (res_st.have_start) begin
      result.start_line   = res_st.held_line;
      result.start_column = res_st.held_column;
      result.start_pos    = res_st.held_pos;
    end else begin
      result.start_line   = res_st.line;
      result.start_column = res_st.column;
      result.start_pos    = res_st.pos;
    end
    result.end_line   = res_st.line;
    result.end_column = res_st.column;
    result.end_pos    = res_st.pos;

    at_end_ofs = ({1'b0, res_st.pos} == end_offset);
    tab_step   = (res_phase == '0) ? 5'd1 : (TAB_PLUS1 - 5'(res_phase));

    emit       = 1'b0;
    state_next = state;
    phase_next = phase;
    if (is_end) begin
      // End of source: report unless stopped, then restart
      emit       = !state.scan_done;
      state_next = SCAN_INIT;
      phase_next = PHASE_INIT;
    end else if (state.scan_done) begin
      emit = 1'b0;
    end else if (at_end_ofs) begin
      emit                 = 1'b1;
      state_next           = res_st;
      state_next.scan_done = 1'b1;
      phase_next           = res_phase;
    end else begin
      state_next     = res_st;
      phase_next     = res_phase;
      state_next.pos = sat_add(res_st.pos, 5'd1);
      priority if (src_byte == CH_CR) begin
        state_next.pending_cr = 1'b1;
      end else if (src_byte == CH_LF) begin
        state_next.line   = sat_add(res_st.line, 5'd1);
        state_next.column = CNT_W'(1);
        phase_next        = PHASE_INIT;
      end else if (src_byte == CH_TAB) begin
        // Next tab stop always lands on the phase of column 1
        state_next.column = sat_add(res_st.column, tab_step);
        phase_next        = PHASE_INIT;
      end else begin
        state_next.column = sat_add(res_st.column, 5'd1);
        phase_next        = (res_phase == PHASE_LAST) ? '0 : res_phase + PW'(1);
      end
    end
  end

endmodule
